/* src/tsf_pkg.sv */
// Package: types, codes and reset constants shared by the telemetry source failover unit.
package tsf_pkg;

  localparam int CMD_W      = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  localparam logic [7:0] DECAY_CLAMP_MS = 8'd200;

  localparam logic [1:0]  RST_SOURCE_PREF    = 2'd0;
  localparam logic [1:0]  RST_TRANSPORT_PREF = 2'd0;
  localparam logic [15:0] RST_ENGINE_START   = 16'd300;
  localparam logic [15:0] RST_IGN_TIMEOUT    = 16'd5000;
  localparam logic [15:0] RST_BUS_FRESH      = 16'd1200;
  localparam logic [15:0] RST_NET_FRESH      = 16'd2000;
  localparam logic [15:0] RST_HOLD           = 16'd500;
  localparam logic [7:0]  RST_DECAY          = 8'd20;

  localparam logic [1:0] SP_BUS_ONLY = 2'd1;
  localparam logic [1:0] SP_SIM_ONLY = 2'd2;
  localparam logic [1:0] TP_USB_ONLY = 2'd1;
  localparam logic [1:0] TP_NET_ONLY = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_BUS_SAMPLE = 3'd1,
    CMD_BUS_DISC   = 3'd2,
    CMD_USB_SAMPLE = 3'd3,
    CMD_NET_SAMPLE = 3'd4
  } tsf_cmd_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_USB  = 2'd1,
    SRC_NET  = 2'd2,
    SRC_BUS  = 2'd3
  } tsf_source_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SOURCE_PREF    = 3'd0,
    REG_TRANSPORT_PREF = 3'd1,
    REG_ENGINE_START   = 3'd2,
    REG_IGN_TIMEOUT    = 3'd3,
    REG_BUS_FRESH      = 3'd4,
    REG_NET_FRESH      = 3'd5,
    REG_HOLD           = 3'd6,
    REG_DECAY          = 3'd7
  } tsf_reg_t;

  typedef struct packed {
    logic [1:0]  source_pref;
    logic [1:0]  transport_pref;
    logic [15:0] engine_start;
    logic [15:0] ign_timeout;
    logic [15:0] bus_fresh;
    logic [15:0] net_fresh;
    logic [15:0] hold;
    logic [7:0]  decay;
  } tsf_cfg_t;

  typedef struct packed {
    logic usb;
    logic net;
    logic bus;
    logic hold_ok;
  } tsf_fresh_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic [15:0] max;
    logic [9:0]  speed;
    logic [3:0]  gear;
    logic [7:0]  thr;
    logic        pit;
    logic [31:0] time_ms;
  } tsf_sample_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic [15:0] max;
    logic [9:0]  speed;
    logic [3:0]  gear;
    logic [7:0]  thr;
    logic        pit;
    logic        ign;
    logic        run;
    logic [31:0] sample_ms;
  } tsf_shown_t;

  // Packed MSB first, so source lands in the low bits of tdata.
  typedef struct packed {
    logic        switched;
    logic        run;
    logic        ign;
    logic        pit;
    logic [7:0]  thr;
    logic [3:0]  gear;
    logic [9:0]  speed;
    logic [15:0] max;
    logic [15:0] rpm;
    tsf_source_t source;
  } tsf_result_t;

endpackage

/* src/tsf_select.sv */
// Source choice from preferences, freshness and the auto-transport hold window.
module tsf_select import tsf_pkg::*; (
  input  logic [1:0]  source_pref,
  input  logic [1:0]  transport_pref,
  input  tsf_fresh_t  fresh,
  input  tsf_source_t active_src,
  output tsf_source_t next_src
);

  logic        bus_only;
  logic        tr_auto;
  tsf_source_t sim;
  tsf_source_t pick;

  always_comb begin
    bus_only = (source_pref == SP_BUS_ONLY);
    tr_auto  = (transport_pref != TP_USB_ONLY) && (transport_pref != TP_NET_ONLY);
    sim      = SRC_NONE;
    if (!bus_only) begin
      priority if (transport_pref == TP_USB_ONLY) begin
        sim = fresh.usb ? SRC_USB : SRC_NONE;
      end else if (transport_pref == TP_NET_ONLY) begin
        sim = fresh.net ? SRC_NET : SRC_NONE;
      end else begin
        sim = fresh.usb ? SRC_USB : (fresh.net ? SRC_NET : SRC_NONE);
      end
    end

    priority if (bus_only) begin
      pick = fresh.bus ? SRC_BUS : SRC_NONE;
    end else if (source_pref == SP_SIM_ONLY) begin
      pick = sim;
    end else begin
      pick = (sim != SRC_NONE) ? sim : (fresh.bus ? SRC_BUS : SRC_NONE);
    end

    next_src = pick;
    if (!bus_only && tr_auto && pick == SRC_NONE && active_src != SRC_NONE && fresh.hold_ok) begin
      next_src = active_src;
    end
  end

endmodule

/* src/telemetry_source_failover_unit.sv */
// Top level: telemetry source failover with input register, state update and result register.
// An item passes the input register and then the result register; it leaves the input register
// only when the result register is empty or its result is taken with out_tready.
// Throughput: one transaction per cycle while out_tready holds; the state update for an item
// is a single pass whose longest path is the 32-bit elapsed-time subtract, the 8x8 decay
// multiply and a 16-bit subtract. Reset (rst_n low, synchronous): all source and display state
// cleared, configuration registers return to their defaults, both pipeline stages empty.
module telemetry_source_failover_unit import tsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_ms[31:0] rpm[47:32] speed_kmh[57:48] gear[61:58] throttle[69:62] pit_limiter[70]
  // usb_fresh[71] bus_connected[72], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[2:0]
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // source[1:0] out_rpm[17:2] out_max_rpm[33:18] out_speed[43:34] out_gear[47:44]
  // out_throttle[55:48] out_pit[56] ignition_on[57] engine_running[58] switched[59]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tsf_cfg_t             cfg_r;
  logic                 s1_valid_r;
  logic [CMD_W-1:0]     s1_cmd_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic                 out_valid_r;
  tsf_result_t          out_r;
  tsf_result_t          out_nxt;

  tsf_sample_t usb_r, net_r, bus_r;
  tsf_sample_t usb_nxt, net_nxt, bus_nxt;
  tsf_shown_t  shown_r, shown_nxt;
  tsf_source_t active_r, active_nxt;
  logic [31:0] last_r, last_nxt;

  logic        adv;
  logic [31:0] now;
  logic [15:0] rpm_in;
  logic [9:0]  speed_in;
  logic [3:0]  gear_in;
  logic [7:0]  thr_in;
  logic        pit_in;
  logic        usb_fresh_in;
  logic        bus_conn_in;

  tsf_fresh_t  fresh;
  tsf_source_t next_src;
  tsf_sample_t sel;
  tsf_sample_t act;
  tsf_shown_t  applied;
  tsf_shown_t  decayed;
  logic [31:0] dt;
  logic [7:0]  dt_clamp;
  logic [15:0] dec;
  logic        ign_expired;
  logic        sw;

  function automatic tsf_sample_t store(tsf_sample_t old, logic [15:0] r, logic [9:0] spd,
                                        logic [3:0] g, logic [7:0] th, logic p,
                                        logic [31:0] t);
    tsf_sample_t s;
    s.rpm     = r;
    s.max     = (r > old.max) ? r : old.max;
    s.speed   = spd;
    s.gear    = g;
    s.thr     = th;
    s.pit     = p;
    s.time_ms = t;
    return s;
  endfunction

  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(tsf_result_t)){1'b0}}, out_r};

  assign now          = s1_data_r[31:0];
  assign rpm_in       = s1_data_r[47:32];
  assign speed_in     = s1_data_r[57:48];
  assign gear_in      = s1_data_r[61:58];
  assign thr_in       = s1_data_r[69:62];
  assign pit_in       = s1_data_r[70];
  assign usb_fresh_in = s1_data_r[71];
  assign bus_conn_in  = s1_data_r[72];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_pref    <= RST_SOURCE_PREF;
      cfg_r.transport_pref <= RST_TRANSPORT_PREF;
      cfg_r.engine_start   <= RST_ENGINE_START;
      cfg_r.ign_timeout    <= RST_IGN_TIMEOUT;
      cfg_r.bus_fresh      <= RST_BUS_FRESH;
      cfg_r.net_fresh      <= RST_NET_FRESH;
      cfg_r.hold           <= RST_HOLD;
      cfg_r.decay          <= RST_DECAY;
    end else if (cfg_we) begin
      unique case (tsf_reg_t'(cfg_addr))
        REG_SOURCE_PREF:    cfg_r.source_pref    <= cfg_wdata[1:0];
        REG_TRANSPORT_PREF: cfg_r.transport_pref <= cfg_wdata[1:0];
        REG_ENGINE_START:   cfg_r.engine_start   <= cfg_wdata;
        REG_IGN_TIMEOUT:    cfg_r.ign_timeout    <= cfg_wdata;
        REG_BUS_FRESH:      cfg_r.bus_fresh      <= cfg_wdata;
        REG_NET_FRESH:      cfg_r.net_fresh      <= cfg_wdata;
        REG_HOLD:           cfg_r.hold           <= cfg_wdata;
        REG_DECAY:          cfg_r.decay          <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Freshness and hold window
  always_comb begin
    unique case (active_r)
      SRC_USB: act = usb_r;
      SRC_NET: act = net_r;
      SRC_BUS: act = bus_r;
      default: act = usb_r;
    endcase
    fresh.usb     = usb_fresh_in;
    fresh.net     = (net_r.time_ms != '0) &&
                    ((now - net_r.time_ms) <= {16'b0, cfg_r.net_fresh});
    fresh.bus     = bus_conn_in && (bus_r.time_ms != '0) &&
                    ((now - bus_r.time_ms) <= {16'b0, cfg_r.bus_fresh});
    fresh.hold_ok = (act.time_ms != '0) && ((now - act.time_ms) <= {16'b0, cfg_r.hold});
  end

  tsf_select u_select (
    .source_pref    (cfg_r.source_pref),
    .transport_pref (cfg_r.transport_pref),
    .fresh          (fresh),
    .active_src     (active_r),
    .next_src       (next_src)
  );

  // Display values for a chosen source; with none, rpm decay and cleared speed/gear/thr/pit
  always_comb begin
    unique case (next_src)
      SRC_USB: sel = usb_r;
      SRC_NET: sel = net_r;
      SRC_BUS: sel = bus_r;
      default: sel = usb_r;
    endcase
    applied.rpm       = sel.rpm;
    applied.max       = sel.max;
    applied.speed     = sel.speed;
    applied.gear      = sel.gear;
    applied.thr       = sel.thr;
    applied.pit       = sel.pit;
    applied.ign       = 1'b1;
    applied.run       = (sel.rpm > cfg_r.engine_start);
    applied.sample_ms = sel.time_ms;

    dt          = (last_r == '0) ? '0 : (now - last_r);
    dt_clamp    = (dt > {24'b0, DECAY_CLAMP_MS}) ? DECAY_CLAMP_MS : dt[7:0];
    dec         = {8'b0, cfg_r.decay} * {8'b0, dt_clamp};
    ign_expired = (shown_r.sample_ms != '0) &&
                  ((now - shown_r.sample_ms) > {16'b0, cfg_r.ign_timeout});

    decayed           = shown_r;
    decayed.rpm       = (dec >= shown_r.rpm) ? '0 : (shown_r.rpm - dec);
    decayed.speed     = '0;
    decayed.gear      = '0;
    decayed.thr       = '0;
    decayed.pit       = 1'b0;
    if (ign_expired) begin
      decayed.ign = 1'b0;
      decayed.run = 1'b0;
    end
  end

  // State update for the item in the input register
  always_comb begin
    usb_nxt    = usb_r;
    net_nxt    = net_r;
    bus_nxt    = bus_r;
    shown_nxt  = shown_r;
    active_nxt = active_r;
    last_nxt   = last_r;
    sw         = 1'b0;
    if (adv) begin
      unique case (s1_cmd_r)
        CMD_TICK: begin
          active_nxt = next_src;
          sw         = (next_src != active_r);
          last_nxt   = now;
          shown_nxt  = (next_src != SRC_NONE) ? applied : decayed;
        end
        CMD_BUS_SAMPLE: bus_nxt = store(bus_r, rpm_in, speed_in, gear_in, '0, 1'b0, now);
        CMD_BUS_DISC: begin
          bus_nxt.rpm   = '0;
          bus_nxt.speed = '0;
          bus_nxt.gear  = '0;
        end
        CMD_USB_SAMPLE: usb_nxt = store(usb_r, rpm_in, speed_in, gear_in, thr_in, pit_in, now);
        CMD_NET_SAMPLE: net_nxt = store(net_r, rpm_in, speed_in, gear_in, thr_in, pit_in, now);
        default: ;
      endcase
    end
    out_nxt.switched = sw;
    out_nxt.run      = shown_nxt.run;
    out_nxt.ign      = shown_nxt.ign;
    out_nxt.pit      = shown_nxt.pit;
    out_nxt.thr      = shown_nxt.thr;
    out_nxt.gear     = shown_nxt.gear;
    out_nxt.speed    = shown_nxt.speed;
    out_nxt.max      = shown_nxt.max;
    out_nxt.rpm      = shown_nxt.rpm;
    out_nxt.source   = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usb_r    <= '0;
      net_r    <= '0;
      bus_r    <= '0;
      shown_r  <= '0;
      active_r <= SRC_NONE;
      last_r   <= '0;
    end else begin
      usb_r    <= usb_nxt;
      net_r    <= net_nxt;
      bus_r    <= bus_nxt;
      shown_r  <= shown_nxt;
      active_r <= active_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  a_src_implies_ign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.source != SRC_NONE |-> out_r.ign)
    else $error("active source without ignition");

  a_run_implies_ign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.run |-> out_r.ign)
    else $error("engine running without ignition");

  a_sample_keeps_src: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_cmd_r != CMD_TICK |=> $stable(active_r))
    else $error("non-tick transaction changed active source");

  a_switch_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_cmd_r != CMD_TICK |=> !out_r.switched)
    else $error("switched flagged on non-tick transaction");

endmodule
